[design/otp_awb_pkg.sv]
package otp_awb_pkg;

    // Field widths
    localparam int unsigned RatioW = 10;
    localparam int unsigned QuotW  = 20;
    localparam int unsigned NumW   = 30;
    localparam int unsigned GainW  = 16;

    // Fixed arithmetic constants
    localparam logic [RatioW-1:0] RatioResetVal = 10'd611;
    localparam logic [QuotW-1:0]  RatioScale    = 20'd1000;
    localparam logic [NumW-1:0]   GreenNum      = 30'd1024000;
    localparam logic [GainW-1:0]  UnityGain     = 16'h0400;

    // Flag byte field masks and the code that marks a group valid
    localparam logic [7:0] FlagG1Mask = 8'hC0;
    localparam logic [7:0] FlagG1Ok   = 8'h40;
    localparam logic [7:0] FlagG2Mask = 8'h30;
    localparam logic [7:0] FlagG2Ok   = 8'h10;
    localparam logic [7:0] FlagG3Mask = 8'h0C;
    localparam logic [7:0] FlagG3Ok   = 8'h04;

    // Register indexes
    localparam logic [1:0] CFG_TYPICAL_RG = 2'd0;
    localparam logic [1:0] CFG_TYPICAL_BG = 2'd1;

    // Status codes
    localparam logic [1:0] ST_COMPUTED = 2'd0;
    localparam logic [1:0] ST_CACHED   = 2'd1;
    localparam logic [1:0] ST_NO_GROUP = 2'd2;
    localparam logic [1:0] ST_ZERO     = 2'd3;

    typedef struct packed {
        logic [7:0] otp_flag;
        logic [7:0] g1_rg_high;
        logic [7:0] g1_bg_high;
        logic [7:0] g1_low_bits;
        logic [7:0] g2_rg_high;
        logic [7:0] g2_bg_high;
        logic [7:0] g2_low_bits;
        logic [7:0] g3_rg_high;
        logic [7:0] g3_bg_high;
        logic [7:0] g3_low_bits;
    } t_in_item;

    typedef struct packed {
        logic [GainW-1:0] red_gain;
        logic [GainW-1:0] green_gain;
        logic [GainW-1:0] blue_gain;
        logic             red_apply;
        logic             green_apply;
        logic             blue_apply;
        logic [1:0]       status;
    } t_out_item;

    typedef struct packed {
        logic            start;
        logic [NumW-1:0] num;
        logic [QuotW-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic            done;
        logic [NumW-1:0] quot;
    } t_div_rsp;

endpackage

[design/otp_awb_divider.sv]
module otp_awb_divider (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  otp_awb_pkg::t_div_req i_req,
    output otp_awb_pkg::t_div_rsp o_rsp
);
    import otp_awb_pkg::*;

    localparam int unsigned DivSteps = NumW;
    localparam int unsigned CntW     = $clog2(DivSteps + 1);

    logic              r_busy;
    logic              r_done;
    logic [CntW-1:0]   r_cnt;
    logic [QuotW-1:0]  r_rem;
    logic [QuotW-1:0]  r_den;
    logic [NumW-1:0]   r_quot;

    logic [QuotW:0]    trial;
    logic [QuotW:0]    diff;
    logic              ge;
    logic [QuotW-1:0]  n_rem;

    // One restoring step: shift in the next dividend bit, try the subtract
    always_comb begin
        trial = {r_rem, r_quot[NumW-1]};
        diff  = trial - {1'b0, r_den};
        ge    = (trial >= {1'b0, r_den});
        n_rem = ge ? diff[QuotW-1:0] : trial[QuotW-1:0];
    end

    // Control: step count and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CntW'(DivSteps);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CntW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= '0;
            r_den  <= i_req.den;
            r_quot <= i_req.num;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_quot <= {r_quot[NumW-2:0], ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

[design/otp_awb_gain_calculator.sv]
// When the cache is valid or the item is rejected (no valid group, zero ratio),
// the item goes straight to the output state; otherwise gains are computed by
// five 30-step divisions on the one shared radix-2 divider.
// Throughput: one item at a time; input stall is high until the result moves
// to the output register. Reset (synchronous, active low) clears the cache,
// loads both typical ratios with 611 and empties the output register.
module otp_awb_gain_calculator (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  otp_awb_pkg::t_in_item  i_in_item,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output otp_awb_pkg::t_out_item o_out_item,
    input  logic                   i_cfg_we,
    input  logic [1:0]             i_cfg_index,
    input  logic [9:0]             i_cfg_data
);
    import otp_awb_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_GO   = 3'd1;
    localparam logic [2:0] S_WAIT = 3'd2;
    localparam logic [2:0] S_BASE = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    localparam logic [2:0] PH_RG    = 3'd0;
    localparam logic [2:0] PH_BG    = 3'd1;
    localparam logic [2:0] PH_RED   = 3'd2;
    localparam logic [2:0] PH_GREEN = 3'd3;
    localparam logic [2:0] PH_BLUE  = 3'd4;

    logic [2:0]        r_state;
    logic [2:0]        r_phase;
    logic [RatioW-1:0] r_typ_rg;
    logic [RatioW-1:0] r_typ_bg;
    logic [GainW-1:0]  r_cache_red;
    logic [GainW-1:0]  r_cache_green;
    logic [GainW-1:0]  r_cache_blue;
    logic [RatioW-1:0] r_rg;
    logic [RatioW-1:0] r_bg;
    logic [QuotW-1:0]  r_rgr;
    logic [QuotW-1:0]  r_bgr;
    logic [QuotW-1:0]  r_base;
    logic [GainW-1:0]  r_red;
    logic [GainW-1:0]  r_green;
    logic [GainW-1:0]  r_blue;
    logic [1:0]        r_status;
    logic              r_out_valid;
    t_out_item         r_out_item;

    logic              accept;
    logic              cache_hit;
    logic              grp_found;
    logic [7:0]        sel_rg_hi;
    logic [7:0]        sel_bg_hi;
    logic [7:0]        sel_low;
    logic [RatioW-1:0] sel_rg;
    logic [RatioW-1:0] sel_bg;
    logic [QuotW-1:0]  ratio_min;
    logic [QuotW-1:0]  base_val;
    logic [QuotW-1:0]  typ_prod;
    logic [GainW-1:0]  quot_sat;
    logic              out_free;
    t_div_req          div_req;
    t_div_rsp          div_rsp;

    assign accept    = i_in_valid && !o_in_stall;
    assign cache_hit = (r_cache_red != '0) || (r_cache_green != '0) || (r_cache_blue != '0);
    assign out_free  = !r_out_valid || !i_out_stall;

    // Pick the first group whose flag field marks it valid
    always_comb begin
        grp_found = 1'b1;
        sel_rg_hi = i_in_item.g1_rg_high;
        sel_bg_hi = i_in_item.g1_bg_high;
        sel_low   = i_in_item.g1_low_bits;
        if ((i_in_item.otp_flag & FlagG1Mask) == FlagG1Ok) begin
            sel_rg_hi = i_in_item.g1_rg_high;
        end else if ((i_in_item.otp_flag & FlagG2Mask) == FlagG2Ok) begin
            sel_rg_hi = i_in_item.g2_rg_high;
            sel_bg_hi = i_in_item.g2_bg_high;
            sel_low   = i_in_item.g2_low_bits;
        end else if ((i_in_item.otp_flag & FlagG3Mask) == FlagG3Ok) begin
            sel_rg_hi = i_in_item.g3_rg_high;
            sel_bg_hi = i_in_item.g3_bg_high;
            sel_low   = i_in_item.g3_low_bits;
        end else begin
            grp_found = 1'b0;
        end
        sel_rg = {sel_rg_hi, sel_low[7:6]};
        sel_bg = {sel_bg_hi, sel_low[5:4]};
    end

    // Normalization base: smaller ratio when either is below scale
    always_comb begin
        ratio_min = (r_rgr < r_bgr) ? r_rgr : r_bgr;
        if ((r_rgr < RatioScale) || (r_bgr < RatioScale)) begin
            base_val = ratio_min;
        end else begin
            base_val = RatioScale;
        end
    end

    // Divider operands for the current phase
    always_comb begin
        typ_prod      = '0;
        div_req.start = (r_state == S_GO);
        div_req.num   = '0;
        div_req.den   = r_base;
        case (r_phase)
            PH_RG: begin
                typ_prod    = QuotW'(r_typ_rg) * RatioScale;
                div_req.num = NumW'(typ_prod);
                div_req.den = QuotW'(r_rg);
            end
            PH_BG: begin
                typ_prod    = QuotW'(r_typ_bg) * RatioScale;
                div_req.num = NumW'(typ_prod);
                div_req.den = QuotW'(r_bg);
            end
            PH_RED:   div_req.num = {r_rgr, 10'b0};
            PH_GREEN: div_req.num = GreenNum;
            PH_BLUE:  div_req.num = {r_bgr, 10'b0};
            default: begin
                div_req.num = '0;
            end
        endcase
    end

    // Saturate a quotient to the gain width
    assign quot_sat = (div_rsp.quot[NumW-1:GainW] != '0) ? '1 : div_rsp.quot[GainW-1:0];

    otp_awb_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Sequencer, configuration, cache and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_phase       <= PH_RG;
            r_typ_rg      <= RatioResetVal;
            r_typ_bg      <= RatioResetVal;
            r_cache_red   <= '0;
            r_cache_green <= '0;
            r_cache_blue  <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_TYPICAL_RG: r_typ_rg <= i_cfg_data;
                    CFG_TYPICAL_BG: r_typ_bg <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            // Drop the taken result unless a new one loads in this cycle
            if (r_out_valid && !i_out_stall && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_phase <= PH_RG;
                        if (cache_hit || !grp_found || sel_rg == '0 || sel_bg == '0) begin
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_GO;
                        end
                    end
                end
                S_GO: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (div_rsp.done) begin
                        case (r_phase)
                            PH_RG: begin
                                r_phase <= PH_BG;
                                r_state <= S_GO;
                            end
                            PH_BG:    r_state <= S_BASE;
                            PH_RED: begin
                                r_phase <= PH_GREEN;
                                r_state <= S_GO;
                            end
                            PH_GREEN: begin
                                r_phase <= PH_BLUE;
                                r_state <= S_GO;
                            end
                            default:  r_state <= S_OUT;
                        endcase
                    end
                end
                S_BASE: begin
                    r_phase <= PH_RED;
                    r_state <= (base_val == '0) ? S_OUT : S_GO;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                        if (r_status == ST_COMPUTED) begin
                            r_cache_red   <= r_red;
                            r_cache_green <= r_green;
                            r_cache_blue  <= r_blue;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Working payload: ratios, base, gains and status
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_rg <= sel_rg;
                    r_bg <= sel_bg;
                    if (cache_hit) begin
                        r_status <= ST_CACHED;
                        r_red    <= r_cache_red;
                        r_green  <= r_cache_green;
                        r_blue   <= r_cache_blue;
                    end else begin
                        r_red   <= '0;
                        r_green <= '0;
                        r_blue  <= '0;
                        if (!grp_found) begin
                            r_status <= ST_NO_GROUP;
                        end else if (sel_rg == '0 || sel_bg == '0) begin
                            r_status <= ST_ZERO;
                        end else begin
                            r_status <= ST_COMPUTED;
                        end
                    end
                end
            end
            S_WAIT: begin
                if (div_rsp.done) begin
                    case (r_phase)
                        PH_RG:    r_rgr   <= div_rsp.quot[QuotW-1:0];
                        PH_BG:    r_bgr   <= div_rsp.quot[QuotW-1:0];
                        PH_RED:   r_red   <= quot_sat;
                        PH_GREEN: r_green <= quot_sat;
                        default:  r_blue  <= quot_sat;
                    endcase
                end
            end
            S_BASE: begin
                r_base <= base_val;
                if (base_val == '0) begin
                    r_status <= ST_ZERO;
                end
            end
            default: begin
            end
        endcase
    end

    // Load the output register
    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            r_out_item.red_gain    <= r_red;
            r_out_item.green_gain  <= r_green;
            r_out_item.blue_gain   <= r_blue;
            r_out_item.red_apply   <= (r_red > UnityGain);
            r_out_item.green_apply <= (r_green > UnityGain);
            r_out_item.blue_apply  <= (r_blue > UnityGain);
            r_out_item.status      <= r_status;
        end
    end

    assign o_in_stall  = !i_rst_n || (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
